// File: hw/rtl/sscs_pkg.sv
// ----------------------------------------------------------------------------
// sscs_pkg
// Shared types and byte codes for the shell statement completeness scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package sscs_pkg;

    localparam int unsigned OPEN_BRACES_W = 16;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LESS      = 8'h3C;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;

    // less-than run codes
    typedef enum logic [1:0] {
        LT_NONE   = 2'd0,
        LT_ONE    = 2'd1,
        LT_DOUBLE = 2'd2
    } t_lt_run;

    typedef struct packed {
        logic                     complete;
        logic [OPEN_BRACES_W-1:0] open_braces;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/sscs_core.sv
// ----------------------------------------------------------------------------
// sscs_core
// Scanner state, delimiter store and the per-byte next-state logic.
// ----------------------------------------------------------------------------
`default_nettype none

module sscs_core #(
    parameter int unsigned HEREDOC_BUFFER = 64,
    parameter int unsigned BRACE_BITS     = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_text_byte,
    input  wire logic             i_first_of_buffer,
    output sscs_pkg::t_result     o_result
);

    localparam int unsigned DELIM_MAX = HEREDOC_BUFFER - 1;
    localparam int unsigned LEN_W     = $clog2(HEREDOC_BUFFER);
    localparam int unsigned ADDR_W    = (DELIM_MAX > 1) ? $clog2(DELIM_MAX) : 1;
    localparam logic [LEN_W-1:0]      LEN_MAX   = LEN_W'(DELIM_MAX);
    localparam logic [BRACE_BITS-1:0] BRACE_MAX = {BRACE_BITS{1'b1}};
    localparam logic [31:0]           CLAMP_MAX =
        32'((64'd1 << sscs_pkg::OPEN_BRACES_W) - 64'd1);

    logic                  r_sq, n_sq;
    logic                  r_dq, n_dq;
    logic                  r_esc, n_esc;
    sscs_pkg::t_lt_run     r_lt, n_lt;
    logic                  r_aw, n_aw;
    logic                  r_hb, n_hb;
    logic [LEN_W-1:0]      r_dlen, n_dlen;
    logic [LEN_W-1:0]      r_blen, n_blen;
    logic                  r_bm, n_bm;
    logic [BRACE_BITS-1:0] r_brace, n_brace;

    logic [7:0]            r_store [DELIM_MAX];
    logic [7:0]            r_rd;
    logic                  wr_en;
    logic [LEN_W-1:0]      waddr;
    logic [LEN_W-1:0]      raddr;
    logic [31:0]           brace_ext;

    always_comb begin
        logic              skip;
        logic              aw_e;
        logic [LEN_W-1:0]  dlen_e;
        logic [7:0]        c;
        sscs_pkg::t_lt_run lt_e;

        c = i_text_byte;
        if (i_first_of_buffer) begin
            n_sq    = 1'b0;
            n_dq    = 1'b0;
            n_esc   = 1'b0;
            n_lt    = sscs_pkg::LT_NONE;
            n_aw    = 1'b0;
            n_hb    = 1'b0;
            n_dlen  = '0;
            n_blen  = '0;
            n_bm    = 1'b1;
            n_brace = '0;
        end else begin
            n_sq    = r_sq;
            n_dq    = r_dq;
            n_esc   = r_esc;
            n_lt    = r_lt;
            n_aw    = r_aw;
            n_hb    = r_hb;
            n_dlen  = r_dlen;
            n_blen  = r_blen;
            n_bm    = r_bm;
            n_brace = r_brace;
        end
        wr_en  = 1'b0;
        waddr  = n_dlen;
        skip   = 1'b0;
        aw_e   = n_aw;
        dlen_e = n_dlen;
        lt_e   = n_lt;

        if (n_hb) begin
            // incremental compare of the body line against the delimiter
            if (c == sscs_pkg::CH_NEWLINE) begin
                if (n_blen == n_dlen && n_bm) begin
                    n_hb   = 1'b0;
                    n_dlen = '0;
                end
                n_blen = '0;
                n_bm   = 1'b1;
            end else if (n_blen < LEN_MAX) begin
                if (n_blen >= n_dlen || r_rd != c) begin
                    n_bm = 1'b0;
                end
                n_blen = n_blen + 1'b1;
            end
        end else begin
            if (lt_e == sscs_pkg::LT_DOUBLE) begin
                n_lt = sscs_pkg::LT_NONE;
                if (c == sscs_pkg::CH_LESS) begin
                    skip = 1'b1;
                end else begin
                    aw_e   = 1'b1;
                    dlen_e = '0;
                    n_aw   = 1'b1;
                    n_dlen = '0;
                end
            end
            if (!skip) begin
                if (aw_e) begin
                    if (c == sscs_pkg::CH_SPACE || c == sscs_pkg::CH_TAB) begin
                        if (dlen_e != '0) begin
                            n_aw = 1'b0;
                        end
                    end else if (c == sscs_pkg::CH_NEWLINE) begin
                        if (dlen_e != '0) begin
                            n_aw   = 1'b0;
                            n_hb   = 1'b1;
                            n_blen = '0;
                            n_bm   = 1'b1;
                        end
                    end else if (dlen_e < LEN_MAX) begin
                        wr_en  = 1'b1;
                        waddr  = dlen_e;
                        n_dlen = dlen_e + 1'b1;
                    end
                end else if (n_sq) begin
                    if (c == sscs_pkg::CH_SQUOTE) begin
                        n_sq = 1'b0;
                    end
                end else if (n_dq) begin
                    if (n_esc) begin
                        n_esc = 1'b0;
                        if (c == sscs_pkg::CH_DQUOTE || c == sscs_pkg::CH_BACKSLASH ||
                            c == sscs_pkg::CH_DOLLAR) begin
                            skip = 1'b1;
                        end
                    end
                    if (!skip) begin
                        if (c == sscs_pkg::CH_BACKSLASH) begin
                            n_esc = 1'b1;
                        end else if (c == sscs_pkg::CH_DQUOTE) begin
                            n_dq = 1'b0;
                        end
                    end
                end else begin
                    if (lt_e == sscs_pkg::LT_ONE) begin
                        n_lt = sscs_pkg::LT_NONE;
                        if (c == sscs_pkg::CH_LESS) begin
                            n_lt = sscs_pkg::LT_DOUBLE;
                            skip = 1'b1;
                        end
                    end
                    if (!skip) begin
                        case (c)
                            sscs_pkg::CH_SQUOTE: begin
                                n_sq = 1'b1;
                            end
                            sscs_pkg::CH_DQUOTE: begin
                                n_dq  = 1'b1;
                                n_esc = 1'b0;
                            end
                            sscs_pkg::CH_LESS: begin
                                n_lt = sscs_pkg::LT_ONE;
                            end
                            sscs_pkg::CH_NEWLINE: begin
                                if (n_dlen != '0) begin
                                    n_hb   = 1'b1;
                                    n_blen = '0;
                                    n_bm   = 1'b1;
                                end
                            end
                            sscs_pkg::CH_LBRACE: begin
                                if (n_brace != BRACE_MAX) begin
                                    n_brace = n_brace + 1'b1;
                                end
                            end
                            sscs_pkg::CH_RBRACE: begin
                                if (n_brace != '0) begin
                                    n_brace = n_brace - 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
        end
    end

    // result from the post-update state
    assign brace_ext = 32'(n_brace);
    always_comb begin
        o_result.complete = !n_sq && !n_dq && (n_brace == '0) && !n_aw &&
                            (n_lt != sscs_pkg::LT_DOUBLE) && !n_hb;
        if (brace_ext > CLAMP_MAX) begin
            o_result.open_braces = CLAMP_MAX[sscs_pkg::OPEN_BRACES_W-1:0];
        end else begin
            o_result.open_braces = brace_ext[sscs_pkg::OPEN_BRACES_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq    <= 1'b0;
            r_dq    <= 1'b0;
            r_esc   <= 1'b0;
            r_lt    <= sscs_pkg::LT_NONE;
            r_aw    <= 1'b0;
            r_hb    <= 1'b0;
            r_dlen  <= '0;
            r_blen  <= '0;
            r_bm    <= 1'b1;
            r_brace <= '0;
        end else if (i_accept) begin
            r_sq    <= n_sq;
            r_dq    <= n_dq;
            r_esc   <= n_esc;
            r_lt    <= n_lt;
            r_aw    <= n_aw;
            r_hb    <= n_hb;
            r_dlen  <= n_dlen;
            r_blen  <= n_blen;
            r_bm    <= n_bm;
            r_brace <= n_brace;
        end
    end

    // Delimiter store. Read data tracks entry r_blen of the registered state
    // while r_blen is below LEN_MAX; writes only happen outside the body, so a
    // body compare never sees a stale byte.
    assign raddr = i_accept ? n_blen : r_blen;

    always_ff @(posedge i_clk) begin
        if (i_accept && wr_en) begin
            r_store[waddr[ADDR_W-1:0]] <= i_text_byte;
        end
        if (raddr < LEN_MAX) begin
            r_rd <= r_store[raddr[ADDR_W-1:0]];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/shell_statement_completeness_scanner.sv
// Each accepted byte's result is registered into the result register or skid.
// Throughput: one byte per cycle while o_ready is high; the per-byte update, with
// the heredoc delimiter compare on one registered store read, is combinational.
// A two-entry output stage (result register plus skid) keeps o_ready high
// while one result waits. Reset (i_rst_n low, synchronous) clears scanner
// state and output valids; the delimiter store is not cleared.
// ----------------------------------------------------------------------------
// shell_statement_completeness_scanner
// Per-byte completeness of a shell command buffer (quotes, braces, heredocs).
// ----------------------------------------------------------------------------
`default_nettype none

module shell_statement_completeness_scanner #(
    parameter int unsigned HEREDOC_BUFFER = 64,
    parameter int unsigned BRACE_BITS     = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic [7:0]                            i_text_byte,
    input  wire logic                                  i_first_of_buffer,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic                                       o_complete,
    output logic [sscs_pkg::OPEN_BRACES_W-1:0]         o_open_braces
);

    logic              accept;
    logic              pop;
    sscs_pkg::t_result result;
    sscs_pkg::t_result r_out;
    sscs_pkg::t_result r_skid;
    logic              r_out_valid;
    logic              r_skid_valid;

    assign o_ready = !r_skid_valid;
    assign accept  = i_valid && o_ready;
    assign pop     = r_out_valid && i_ready;

    sscs_core #(
        .HEREDOC_BUFFER (HEREDOC_BUFFER),
        .BRACE_BITS     (BRACE_BITS)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_text_byte       (i_text_byte),
        .i_first_of_buffer (i_first_of_buffer),
        .o_result          (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= result;
            end
        end else if (accept) begin
            if (!r_out_valid) begin
                r_out <= result;
            end else begin
                r_skid <= result;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_complete    = r_out.complete;
    assign o_open_braces = r_out.open_braces;

endmodule

`default_nettype wire

// File: hw/rtl/sscs_checker.sv
// ----------------------------------------------------------------------------
// sscs_checker
// Port-level checks for the scanner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sscs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        o_complete,
    input wire logic [15:0] o_open_braces
);

    // a held result stays until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_complete) &&
                                   $stable(o_open_braces)))
        else $error("output result changed while stalled");

    // complete implies no open braces
    a_complete_braces: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_complete) |-> (o_open_braces == 16'd0))
        else $error("complete reported with open braces");

    // input only stalls when both output entries are full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with empty output");

    // a transfer into an empty output shows up next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !o_valid) |=> o_valid)
        else $error("result missing one cycle after transfer");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("output not cleared by reset");

endmodule

bind shell_statement_completeness_scanner sscs_checker u_sscs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_complete        (o_complete),
    .o_open_braces     (o_open_braces)
);

`default_nettype wire
